@@ hw/rtl/gl3d_pkg.sv @@
package gl3d_pkg;

  // Coordinate width of every coordinate field in the input and result
  localparam int COORD_W = 16;

  // Default limit on the major-axis span
  localparam int MAX_SPAN_DEF = 63;

  // One line request
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } in_req_t;

  // One emitted cell
  typedef struct packed {
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
    logic signed [COORD_W-1:0] cell_z;
    logic                      last;
    logic                      span_error;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture start and end
    logic delta;      // register deltas and step directions
    logic major;      // pick major axis, check span
    logic init;       // seed error terms and cell counter
    logic emit_cell;  // present current cell, then step
    logic emit_err;   // present the span error result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic span_err;   // major delta above the limit
    logic last_cell;  // current cell is the end cell
  } dp_sts_t;

endpackage

@@ hw/rtl/gl3d_ctrl.sv @@
module gl3d_ctrl
  import gl3d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DELTA = 6'b000010,
    S_MAJOR = 6'b000100,
    S_INIT  = 6'b001000,
    S_RUN   = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_MAJOR;
      S_MAJOR: state_nxt = S_INIT;
      S_INIT:  state_nxt = sts.span_err ? S_ERR : S_RUN;
      S_RUN:   if (sts.last_cell) state_nxt = S_IDLE;
      S_ERR:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.delta     = (state_r == S_DELTA);
    cmd.major     = (state_r == S_MAJOR);
    cmd.init      = (state_r == S_INIT);
    cmd.emit_cell = (state_r == S_RUN);
    cmd.emit_err  = (state_r == S_ERR);
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ hw/rtl/gl3d_datapath.sv @@
module gl3d_datapath
  import gl3d_pkg::*;
#(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_req,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  output out_res_t  out_res
);

  localparam int SW = $clog2(MAX_SPAN + 1);  // span / counter width
  localparam int ES = SW + 2;                 // error term width, signed

  logic [COORD_W-1:0]   p_r   [3];
  logic [COORD_W-1:0]   e_r   [3];
  logic [COORD_W-1:0]   d_r   [3];
  logic                 neg_r [3];
  logic signed [ES-1:0] er_r  [3];
  logic signed [ES-1:0] inc_r [3];
  logic signed [ES-1:0] dec_r [3];
  logic [2:0]           maj_r;
  logic                 span_err_r;
  logic [SW-1:0]        dmaj_r;
  logic [SW-1:0]        cnt_r;
  logic                 out_valid_r;
  out_res_t             out_r;

  logic [COORD_W:0]     diff     [3];
  logic [COORD_W-1:0]   absd     [3];
  logic [2:0]           maj_sel;
  logic [COORD_W-1:0]   dsel;
  logic signed [ES-1:0] inc_c    [3];
  logic signed [ES-1:0] dec_c    [3];
  logic signed [ES-1:0] er0_c    [3];
  logic                 step_c   [3];
  logic [COORD_W-1:0]   p_step   [3];
  logic signed [ES-1:0] er_step  [3];

  // Deltas and step directions
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {e_r[a][COORD_W-1], e_r[a]} - {p_r[a][COORD_W-1], p_r[a]};
      absd[a] = diff[a][COORD_W] ? (~diff[a][COORD_W-1:0] + 1'b1)
                                 : diff[a][COORD_W-1:0];
    end
  end

  // Major axis pick, ties to x then y
  always_comb begin
    if (d_r[0] >= d_r[1] && d_r[0] >= d_r[2]) begin
      maj_sel = 3'b001;
      dsel    = d_r[0];
    end else if (d_r[1] >= d_r[2]) begin
      maj_sel = 3'b010;
      dsel    = d_r[1];
    end else begin
      maj_sel = 3'b100;
      dsel    = d_r[2];
    end
  end

  // Error seeds: 2*d - dmaj, with 2*d added and 2*dmaj taken on a step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      inc_c[a] = {1'b0, d_r[a][SW-1:0], 1'b0};
      dec_c[a] = inc_c[a] - {1'b0, dmaj_r, 1'b0};
      er0_c[a] = inc_c[a] - {2'b00, dmaj_r};
    end
  end

  // One Bresenham step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      step_c[a]  = maj_r[a] || !er_r[a][ES-1];
      p_step[a]  = !step_c[a] ? p_r[a] :
                   (neg_r[a] ? (p_r[a] - COORD_W'(1)) : (p_r[a] + COORD_W'(1)));
      er_step[a] = er_r[a] + (step_c[a] ? dec_r[a] : inc_r[a]);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r[0] <= in_req.start_x;
      p_r[1] <= in_req.start_y;
      p_r[2] <= in_req.start_z;
      e_r[0] <= in_req.end_x;
      e_r[1] <= in_req.end_y;
      e_r[2] <= in_req.end_z;
    end
    if (cmd.delta) begin
      for (int a = 0; a < 3; a++) begin
        d_r[a]   <= absd[a];
        neg_r[a] <= diff[a][COORD_W];
      end
    end
    if (cmd.major) begin
      maj_r      <= maj_sel;
      span_err_r <= (dsel > COORD_W'(MAX_SPAN));
      dmaj_r     <= dsel[SW-1:0];
    end
    if (cmd.init) begin
      for (int a = 0; a < 3; a++) begin
        er_r[a]  <= er0_c[a];
        inc_r[a] <= inc_c[a];
        dec_r[a] <= dec_c[a];
      end
      cnt_r <= dmaj_r;
    end
    if (cmd.emit_cell) begin
      for (int a = 0; a < 3; a++) begin
        p_r[a]  <= p_step[a];
        er_r[a] <= er_step[a];
      end
      cnt_r <= cnt_r - SW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit_cell) begin
      out_r.cell_x     <= p_r[0];
      out_r.cell_y     <= p_r[1];
      out_r.cell_z     <= p_r[2];
      out_r.last       <= (cnt_r == '0);
      out_r.span_error <= 1'b0;
    end else if (cmd.emit_err) begin
      out_r.cell_x     <= '0;
      out_r.cell_y     <= '0;
      out_r.cell_z     <= '0;
      out_r.last       <= 1'b1;
      out_r.span_error <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_cell || cmd.emit_err;
    end
  end

  assign sts.span_err  = span_err_r;
  assign sts.last_cell = (cnt_r == '0);
  assign out_valid     = out_valid_r;
  assign out_res       = out_r;

`ifndef ASSERT_OFF
  // Span error result carries no cell and ends the line
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.span_error |->
      out_r.last && out_r.cell_x == '0 && out_r.cell_y == '0 && out_r.cell_z == '0)
    else $error("span error result malformed");

  // Cells of one line come on consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |=> out_valid_r)
    else $error("gap inside a line");

  // Consecutive cells of one line differ (major axis always moves)
  a_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |=>
      out_r.cell_x != $past(out_r.cell_x) || out_r.cell_y != $past(out_r.cell_y) ||
      out_r.cell_z != $past(out_r.cell_z))
    else $error("repeated cell inside a line");
`endif

endmodule

@@ hw/rtl/grid_line_rasterizer_3d.sv @@
// Channel   Ports                   Transfer
// input     start, busy, in_req     taken when start is high and busy is low
// result    out_valid, out_res      one cycle per cell, strobed by out_valid
//
// A line of N cells passes load, delta, major pick and error seed, then gets
// one cell per cycle from the step loop (N = major delta + 1, at most
// MAX_SPAN + 1). A span error gives one error result in place of the cells.
// busy is high from the cycle after a request until its last result is issued.
// Reset is synchronous, active low; it idles the controller and drops out_valid.
// The receiver cannot stall: every strobed result is taken in its cycle.
module grid_line_rasterizer_3d
  import gl3d_pkg::*;
#(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer
  gl3d_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Step engine and result register
  gl3d_datapath #(
    .MAX_SPAN (MAX_SPAN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
